FILE: rtl/core/drn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drn_pkg
// shared types and constants of the debounced note recorder
// ----------------------------------------------------------------------------
package drn_pkg;

   localparam int NOTE_W = 8;
   localparam int POS_W  = 8;
   localparam int TRK_OUT_W = 3;
   localparam int MODE_OUT_W = 3;
   localparam logic [7:0] FRAME_TICKS_RESET = 8'd8;
   localparam logic [2:0] MODE_EDGE_PAT = 3'b100;
   localparam logic [2:0] NO_NOTE_TRACK = 3'd7;

   typedef enum logic [1:0] {
      MODE_PLAY   = 2'd0,
      MODE_RECORD = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_REPLAY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_IDLE = 2'd0,
      ACT_REC  = 2'd1,
      ACT_DEL  = 2'd2,
      ACT_PLAY = 2'd3
   } activity_type;

   typedef enum logic {
      PH_FETCH = 1'b0,
      PH_EXEC  = 1'b1
   } phase_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note_edges;
      logic              mode_edge;
      logic              boundary;
   } tick_type;

endpackage
`default_nettype wire

FILE: rtl/core/drn_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drn_if
// valid/ready channels of the debounced note recorder
// ----------------------------------------------------------------------------
interface drn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] note_pins;
   logic       mode_pin;
   modport source (output valid, output note_pins, output mode_pin, input ready);
   modport sink (input valid, input note_pins, input mode_pin, output ready);
endinterface

interface drn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] strike_notes;
   logic [2:0] current_mode;
   logic [1:0] activity;
   logic [2:0] active_track;
   logic [7:0] frame_position;
   logic       frame_boundary;
   logic       track_deleted;
   modport source (output valid, output strike_notes, output current_mode,
                   output activity, output active_track, output frame_position,
                   output frame_boundary, output track_deleted, input ready);
   modport sink (input valid, input strike_notes, input current_mode,
                 input activity, input active_track, input frame_position,
                 input frame_boundary, input track_deleted, output ready);
endinterface

interface drn_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_ticks;
   modport source (output valid, output frame_ticks, input ready);
   modport sink (input valid, input frame_ticks, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/drn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drn_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module drn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/drn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drn_front
// sample history, press edge detection and frame timer
// ----------------------------------------------------------------------------
module drn_front (
   input  logic             clock,
   input  logic             reset,
   drn_req_if.sink          req_ch,
   drn_csr_if.sink          csr_ch,
   input  logic             push_ready,
   output logic             push_valid,
   output drn_pkg::tick_type push_data
);
   import drn_pkg::*;

   logic [7:0] hist_one_ff, hist_two_ff;
   logic [2:0] mode_hist_ff, mode_hist_in;
   logic [7:0] phase_ff, phase_in;
   logic [7:0] frame_ticks_ff;
   logic [8:0] next_phase;
   logic       boundary;
   logic       accept;

   assign req_ch.ready = push_ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && push_ready;
   assign push_valid   = req_ch.valid;

   always_comb begin
      mode_hist_in = {mode_hist_ff[1:0], req_ch.mode_pin};
      next_phase   = {1'b0, phase_ff} + 9'd1;
      boundary     = next_phase >= {1'b0, frame_ticks_ff};
      phase_in     = boundary ? 8'd0 : next_phase[7:0];
      push_data.note_edges = ~(req_ch.note_pins | hist_one_ff) & hist_two_ff;
      push_data.mode_edge  = (mode_hist_in == MODE_EDGE_PAT);
      push_data.boundary   = boundary;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_one_ff    <= '0;
         hist_two_ff    <= '0;
         mode_hist_ff   <= '0;
         phase_ff       <= '0;
         frame_ticks_ff <= FRAME_TICKS_RESET;
      end else begin
         if (accept) begin
            hist_one_ff   <= req_ch.note_pins;
            hist_two_ff   <= hist_one_ff;
            mode_hist_ff  <= mode_hist_in;
            phase_ff      <= phase_in;
         end
         if (csr_ch.valid) begin
            frame_ticks_ff <= csr_ch.frame_ticks;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/drn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drn_queue
// two entry queue of classified ticks between front and back
// ----------------------------------------------------------------------------
module drn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  drn_pkg::tick_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output drn_pkg::tick_type pop_data,
   input  logic              pop
);
   import drn_pkg::*;

   tick_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/drn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drn_back
// mode controller, track store and result register
// ----------------------------------------------------------------------------
module drn_back #(
   parameter int TRACKS      = 8,
   parameter int TRACK_BYTES = 256,
   parameter int MAX_NOTES   = 254
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  drn_pkg::tick_type item,
   output logic              pop,
   drn_rsp_if.source         rsp_ch
);
   import drn_pkg::*;

   localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int DEPTH  = TRACKS * TRACK_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WIDE_W = ADDR_W + POS_W + 1;
   localparam int RECORD_LIMIT = (MAX_NOTES < TRACK_BYTES - 1) ? MAX_NOTES : TRACK_BYTES - 1;

   phase_type    phase_ff, phase_in;
   mode_type     mode_ff, mode_in;
   activity_type act_ff, act_in;
   logic [7:0]   pend_notes_ff, pend_notes_in;
   logic         pend_mode_ff, pend_mode_in;
   logic [2:0]   track_ff, track_in;
   logic [7:0]   pos_ff, pos_in;
   logic [7:0]   len_ff, len_in;
   logic [7:0]   hdr_ff [TRACKS];
   logic         hdr_we;
   logic [7:0]   hdr_wdata;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   strike_ff;
   logic [2:0]   rmode_ff;
   logic [1:0]   ract_ff;
   logic [2:0]   rtrack_ff;
   logic [7:0]   rpos_ff;
   logic         rbound_ff, rdel_ff;

   logic [7:0]   strike;
   logic         deleted;
   logic         exec_go;
   logic [7:0]   merged_notes;
   logic [2:0]   low_idx;
   logic [2:0]   sel_track;
   logic [2:0]   mod_tab [8];
   logic [WIDE_W-1:0] addr_wide;
   logic [ADDR_W-1:0] addr;
   logic         ram_we, ram_re;
   logic [7:0]   ram_rdata;
   logic         pos_in_row;

   for (genvar g = 0; g < 8; g++) begin : g_mod
      assign mod_tab[g] = 3'(g % TRACKS);
   end

   assign addr_wide    = WIDE_W'(track_ff) * WIDE_W'(TRACK_BYTES) + WIDE_W'(pos_ff);
   assign addr         = addr_wide[ADDR_W-1:0];
   assign pos_in_row   = ({1'b0, pos_ff} < 9'(TRACK_BYTES));
   assign exec_go      = (phase_ff == PH_EXEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign pop          = exec_go;
   assign ram_re       = (phase_ff == PH_FETCH) && item_valid;
   assign merged_notes = pend_notes_ff | item.note_edges;

   drn_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (merged_notes),
      .rd_en   (ram_re),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      low_idx = NO_NOTE_TRACK;
      for (int i = 7; i >= 0; i--) begin
         if (merged_notes[i]) begin
            low_idx = 3'(i);
         end
      end
      sel_track = mod_tab[low_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FETCH;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      act_in        = act_ff;
      pend_notes_in = pend_notes_ff;
      pend_mode_in  = pend_mode_ff;
      track_in      = track_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      hdr_we        = 1'b0;
      hdr_wdata     = 8'd0;
      ram_we        = 1'b0;
      strike        = 8'd0;
      deleted       = 1'b0;
      unique case (phase_ff)
         PH_FETCH: begin
            if (item_valid) begin
               phase_in = PH_EXEC;
            end
         end
         PH_EXEC: begin
            if (exec_go) begin
               phase_in      = PH_FETCH;
               pend_notes_in = merged_notes;
               pend_mode_in  = pend_mode_ff | item.mode_edge;
               unique case (act_ff)
                  ACT_IDLE: begin
                     if (pend_mode_in) begin
                        mode_in      = mode_type'(mode_ff + 2'd1);
                        pend_mode_in = 1'b0;
                     end
                     if (pend_notes_in != 8'd0) begin
                        unique case (mode_in)
                           MODE_PLAY: begin
                              strike = pend_notes_in;
                           end
                           MODE_RECORD: begin
                              track_in = sel_track;
                              pos_in   = 8'd1;
                              act_in   = ACT_REC;
                           end
                           MODE_DELETE: begin
                              track_in = sel_track;
                              act_in   = ACT_DEL;
                           end
                           MODE_REPLAY: begin
                              track_in     = sel_track;
                              len_in       = hdr_ff[sel_track[TRK_W-1:0]];
                              pos_in       = 8'd1;
                              pend_mode_in = 1'b0;
                              if (len_in != 8'd0) begin
                                 act_in = ACT_PLAY;
                              end
                           end
                        endcase
                        pend_notes_in = 8'd0;
                     end
                  end
                  ACT_REC: begin
                     if (item.boundary) begin
                        strike        = pend_notes_in;
                        ram_we        = pos_in_row;
                        pend_notes_in = 8'd0;
                        if ({1'b0, pos_ff} >= 9'(RECORD_LIMIT) || pend_mode_in) begin
                           pend_mode_in = 1'b0;
                           hdr_we       = 1'b1;
                           hdr_wdata    = pos_ff;
                           act_in       = ACT_IDLE;
                        end else begin
                           pos_in = pos_ff + 8'd1;
                        end
                     end
                  end
                  ACT_DEL: begin
                     if (pend_mode_in || pend_notes_in != 8'd0) begin
                        if (pend_mode_in) begin
                           hdr_we    = 1'b1;
                           hdr_wdata = 8'd0;
                           deleted   = 1'b1;
                        end
                        pend_mode_in  = 1'b0;
                        pend_notes_in = 8'd0;
                        act_in        = ACT_IDLE;
                     end
                  end
                  ACT_PLAY: begin
                     if (pend_mode_in) begin
                        pend_mode_in  = 1'b0;
                        pend_notes_in = 8'd0;
                        act_in        = ACT_IDLE;
                     end else if (item.boundary) begin
                        strike = pos_in_row ? ram_rdata : 8'd0;
                        if (pos_ff >= len_ff) begin
                           pend_notes_in = 8'd0;
                           act_in        = ACT_IDLE;
                        end else begin
                           pos_in = pos_ff + 8'd1;
                        end
                     end
                  end
               endcase
            end
         end
      endcase
      rsp_valid_in = exec_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PLAY;
         act_ff        <= ACT_IDLE;
         pend_notes_ff <= '0;
         pend_mode_ff  <= 1'b0;
         track_ff      <= '0;
         pos_ff        <= '0;
         len_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < TRACKS; i++) begin
            hdr_ff[i] <= '0;
         end
      end else begin
         mode_ff       <= mode_in;
         act_ff        <= act_in;
         pend_notes_ff <= pend_notes_in;
         pend_mode_ff  <= pend_mode_in;
         track_ff      <= track_in;
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (hdr_we) begin
            hdr_ff[track_ff[TRK_W-1:0]] <= hdr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         strike_ff <= strike;
         rmode_ff  <= {1'b0, mode_in} + 3'd1;
         ract_ff   <= act_in;
         rtrack_ff <= track_in;
         rpos_ff   <= pos_in;
         rbound_ff <= item.boundary;
         rdel_ff   <= deleted;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.strike_notes   = strike_ff;
   assign rsp_ch.current_mode   = rmode_ff;
   assign rsp_ch.activity       = ract_ff;
   assign rsp_ch.active_track   = rtrack_ff;
   assign rsp_ch.frame_position = rpos_ff;
   assign rsp_ch.frame_boundary = rbound_ff;
   assign rsp_ch.track_deleted  = rdel_ff;

endmodule
`default_nettype wire

FILE: rtl/core/debounced_note_recorder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_note_recorder
// button sampler, four mode note controller and track recorder
// ----------------------------------------------------------------------------
// One tick word is taken per cycle, while the queue has room, into a two
// word queue; the controller handles each tick in a read phase and an
// execute phase on the note store, taking no new tick before the last is
// done, and stalls while the result register before the rsp channel holds
// an untaken result. Track length headers sit in flops cleared by reset and
// note bytes are used only once recorded, so reset needs no clearing pass.
// frame_ticks may be written at any time the block is idle; its reset is 8.
module debounced_note_recorder #(
   parameter int TRACKS      = 8,
   parameter int TRACK_BYTES = 256,
   parameter int MAX_NOTES   = 254
) (
   input  logic      clock,
   input  logic      reset,
   drn_req_if.sink   req_ch,
   drn_rsp_if.source rsp_ch,
   drn_csr_if.sink   csr_ch
);
   import drn_pkg::*;

   logic     q_push_valid, q_push_ready;
   tick_type q_push_data;
   logic     q_pop_valid, q_pop;
   tick_type q_pop_data;

   drn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_ready (q_push_ready),
      .push_valid (q_push_valid),
      .push_data  (q_push_data)
   );

   drn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data),
      .pop        (q_pop)
   );

   drn_back #(
      .TRACKS      (TRACKS),
      .TRACK_BYTES (TRACK_BYTES),
      .MAX_NOTES   (MAX_NOTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_pop_valid),
      .item       (q_pop_data),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_pop_valid)
      else $error("pop from empty queue");

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_ch.valid)
      else $error("executed word left no result");

   a_pop_spacing: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop)
      else $error("two words executed in adjacent cycles");

   a_delete_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.track_deleted |-> rsp_ch.activity == ACT_IDLE)
      else $error("delete reported while not idle");

endmodule
`default_nettype wire
